// ----- hw/rtl/u8u16_pkg.sv -----
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

    localparam logic [15:0] CAPACITY_RESET = 16'hFFFF;

    localparam logic [15:0] HI_SURR_BASE = 16'hD800;
    localparam logic [15:0] LO_SURR_BASE = 16'hDC00;
    localparam logic [20:0] SURR_FIRST   = 21'h00D800;
    localparam logic [20:0] SURR_LAST    = 21'h00DFFF;
    localparam logic [20:0] MIN_TWO      = 21'h000080;
    localparam logic [20:0] MIN_THREE    = 21'h000800;
    localparam logic [20:0] MIN_FOUR     = 21'h010000;
    localparam logic [20:0] MAX_POINT    = 21'h10FFFF;
    localparam logic [20:0] SUPP_OFFSET  = 21'h010000;

    // sequence length minus one
    localparam logic [1:0] SEQ_NONE  = 2'd0;
    localparam logic [1:0] SEQ_TWO   = 2'd1;
    localparam logic [1:0] SEQ_THREE = 2'd2;
    localparam logic [1:0] SEQ_FOUR  = 2'd3;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [15:0] code_unit;
        logic        status;
        logic        last;
    } unit_res_t;

    typedef struct packed {
        logic [20:0] partial_point;
        logic [1:0]  bytes_remaining;
        logic [1:0]  sequence_length;
        logic [15:0] units_written;
        logic        discarding;
    } xcode_state_t;

    typedef struct packed {
        logic [1:0] n_res;
        unit_res_t  res0;
        unit_res_t  res1;
    } step_out_t;

endpackage

// ----- hw/rtl/u8u16_step.sv -----
// ----------------------------------------------------------------------------
// u8u16_step
// Per-byte decode: validates one UTF-8 byte against the current sequence
// state, produces zero, one or two UTF-16 results and the next state.
// ----------------------------------------------------------------------------
module u8u16_step (
    input  u8u16_pkg::xcode_state_t st,
    input  logic [7:0]              in_byte,
    input  logic [15:0]             out_capacity,
    output u8u16_pkg::xcode_state_t st_next,
    output u8u16_pkg::step_out_t    step
);
    import u8u16_pkg::*;

    logic [20:0] pp_shift;
    logic [20:0] emit_cp;
    logic [20:0] supp;
    logic        do_emit;
    logic        do_fail;
    logic        fail_disc;
    logic        bad;
    logic [16:0] units_plus1;
    logic [16:0] units_plus2;
    logic [16:0] cap_ext;

    assign pp_shift    = {st.partial_point[14:0], in_byte[5:0]};
    assign units_plus1 = {1'b0, st.units_written} + 17'd1;
    assign units_plus2 = {1'b0, st.units_written} + 17'd2;
    assign cap_ext     = {1'b0, out_capacity};
    assign supp        = emit_cp - SUPP_OFFSET;

    always_comb
    begin
        st_next   = st;
        step      = '0;
        do_emit   = 1'b0;
        do_fail   = 1'b0;
        fail_disc = 1'b0;
        bad       = 1'b0;
        emit_cp   = '0;

        if (st.discarding)
        begin
            if (in_byte == 8'd0)
            begin
                st_next.discarding    = 1'b0;
                st_next.units_written = '0;
            end
        end
        else if (st.bytes_remaining != 2'd0)
        begin
            if (in_byte[7:6] != 2'b10)
            begin
                do_fail   = 1'b1;
                fail_disc = (in_byte != 8'd0);
            end
            else if (st.bytes_remaining != 2'd1)
            begin
                st_next.partial_point   = pp_shift;
                st_next.bytes_remaining = st.bytes_remaining - 2'd1;
            end
            else
            begin
                st_next.partial_point   = '0;
                st_next.bytes_remaining = 2'd0;
                st_next.sequence_length = SEQ_NONE;
                case (st.sequence_length)
                    SEQ_TWO:   bad = (pp_shift < MIN_TWO);
                    SEQ_THREE: bad = (pp_shift < MIN_THREE)
                                     || (pp_shift inside {[SURR_FIRST:SURR_LAST]});
                    default:   bad = (pp_shift < MIN_FOUR) || (pp_shift > MAX_POINT);
                endcase
                if (bad)
                begin
                    do_fail   = 1'b1;
                    fail_disc = 1'b1;
                end
                else
                begin
                    do_emit = 1'b1;
                    emit_cp = pp_shift;
                end
            end
        end
        else if (in_byte == 8'd0)
        begin
            if (st.units_written >= out_capacity)
            begin
                do_fail   = 1'b1;
                fail_disc = 1'b0;
            end
            else
            begin
                step.n_res            = 2'd1;
                step.res0             = '{code_unit: 16'h0000, status: 1'b0, last: 1'b1};
                st_next.units_written = '0;
            end
        end
        else if (!in_byte[7])
        begin
            do_emit = 1'b1;
            emit_cp = {13'd0, in_byte};
        end
        else if (in_byte[7:5] == 3'b110)
        begin
            st_next.partial_point   = {16'd0, in_byte[4:0]};
            st_next.bytes_remaining = 2'd1;
            st_next.sequence_length = SEQ_TWO;
        end
        else if (in_byte[7:4] == 4'b1110)
        begin
            st_next.partial_point   = {17'd0, in_byte[3:0]};
            st_next.bytes_remaining = 2'd2;
            st_next.sequence_length = SEQ_THREE;
        end
        else if (in_byte[7:3] == 5'b11110)
        begin
            st_next.partial_point   = {18'd0, in_byte[2:0]};
            st_next.bytes_remaining = 2'd3;
            st_next.sequence_length = SEQ_FOUR;
        end
        else
        begin
            do_fail   = 1'b1;
            fail_disc = 1'b1;
        end

        if (do_emit)
        begin
            if (emit_cp[20:16] != 5'd0)
            begin
                if (units_plus2 < cap_ext)
                begin
                    step.n_res            = 2'd2;
                    step.res0             = '{code_unit: HI_SURR_BASE | {6'd0, supp[19:10]},
                                              status: 1'b0, last: 1'b0};
                    step.res1             = '{code_unit: LO_SURR_BASE | {6'd0, supp[9:0]},
                                              status: 1'b0, last: 1'b0};
                    st_next.units_written = units_plus2[15:0];
                end
                else
                begin
                    do_fail   = 1'b1;
                    fail_disc = 1'b1;
                end
            end
            else if (units_plus1 < cap_ext)
            begin
                step.n_res            = 2'd1;
                step.res0             = '{code_unit: emit_cp[15:0], status: 1'b0, last: 1'b0};
                st_next.units_written = units_plus1[15:0];
            end
            else
            begin
                do_fail   = 1'b1;
                fail_disc = 1'b1;
            end
        end

        // error ends the string: one result, then drop bytes unless it was the zero byte
        if (do_fail)
        begin
            st_next.partial_point   = '0;
            st_next.bytes_remaining = 2'd0;
            st_next.sequence_length = SEQ_NONE;
            st_next.units_written   = '0;
            st_next.discarding      = fail_disc;
            step.n_res              = 2'd1;
            step.res0               = '{code_unit: 16'h0000, status: 1'b1, last: 1'b1};
            step.res1               = '0;
        end
    end

endmodule

// ----- hw/rtl/u8u16_outq.sv -----
// ----------------------------------------------------------------------------
// u8u16_outq
// Result queue: takes up to two code units per cycle, hands out one per
// transfer on the output channel.
// ----------------------------------------------------------------------------
module u8u16_outq (
    input  logic                            clk,
    input  logic                            rst_n,
    input  u8u16_pkg::step_out_t            push,
    input  logic                            pop,
    output u8u16_pkg::unit_res_t            head,
    output logic [u8u16_pkg::QUEUE_AW:0]    count
);
    import u8u16_pkg::*;

    unit_res_t           entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg;
    logic [QUEUE_AW:0]   count_next;
    logic [QUEUE_AW-1:0] wr_ptr_plus1;

    assign wr_ptr_plus1 = wr_ptr_reg + 1'b1;
    assign head         = entry_reg[rd_ptr_reg];
    assign count        = count_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + push.n_res[QUEUE_AW-1:0];
        rd_ptr_next = rd_ptr_reg + {{(QUEUE_AW-1){1'b0}}, pop};
        count_next  = count_reg + {{(QUEUE_AW-1){1'b0}}, push.n_res}
                      - {{QUEUE_AW{1'b0}}, pop};
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (push.n_res != 2'd0 && wr_ptr_reg == QUEUE_AW'(i))
            begin
                entry_reg[i] <= push.res0;
            end
            else if (push.n_res == 2'd2 && wr_ptr_plus1 == QUEUE_AW'(i))
            begin
                entry_reg[i] <= push.res1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef ASSERT_OFF
    // queue never overfills
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (QUEUE_AW+1)'(QUEUE_DEPTH))
        else $error("result queue overflow");

    // pointers stay consistent with the fill count
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_ptr_reg - rd_ptr_reg) == count_reg[QUEUE_AW-1:0])
        else $error("result queue pointers out of step with count");
`endif

endmodule

// ----- hw/rtl/utf8_to_utf16_transcoder_core.sv -----
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder_core
// Strict UTF-8 to UTF-16 transcoder with output capacity check.
// ----------------------------------------------------------------------------
// Takes one UTF-8 byte per transfer and sustains one byte per clock while the
// result queue has room. A byte sits in an input register, is decoded there,
// and its code units are written into a four-entry result queue, whose head
// drives the output. The output side moves one code unit per transfer; no
// byte yields more than one unit on average (a surrogate pair comes from
// four bytes), so an output that is not stalled always keeps pace with the
// input. Input stalls when a byte is held and the queue holds more than two
// units. An error gives one result with status and last set, after which
// bytes are dropped up to the zero byte, unless the failing byte was itself
// a zero byte. out_capacity must be written through cfg_wr_en/cfg_wr_data
// only while the block is idle; the block itself does not enforce this.
module utf8_to_utf16_transcoder_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] code_unit,
    output logic        status,
    output logic        last
);
    import u8u16_pkg::*;

    logic [15:0]       capacity_reg;
    logic              in_vld_reg;
    logic              in_vld_next;
    logic [7:0]        byte_reg;
    xcode_state_t      state_reg;
    xcode_state_t      state_next;
    xcode_state_t      state_calc;
    step_out_t         step_calc;
    step_out_t         push;
    unit_res_t         head;
    logic [QUEUE_AW:0] q_count;
    logic              proc;
    logic              in_xfer;
    logic              pop;

    // room for a pair must be there before the held byte is decoded
    assign proc     = in_vld_reg && (q_count <= (QUEUE_AW+1)'(QUEUE_DEPTH - 2));
    assign in_stall = in_vld_reg && !proc;
    assign in_xfer  = in_valid && !in_stall;
    assign pop      = out_valid && !out_stall;

    assign out_valid = (q_count != '0);
    assign code_unit = head.code_unit;
    assign status    = head.status;
    assign last      = head.last;

    u8u16_step u_step (
        .st           (state_reg),
        .in_byte      (byte_reg),
        .out_capacity (capacity_reg),
        .st_next      (state_calc),
        .step         (step_calc)
    );

    always_comb
    begin
        push        = proc ? step_calc : '0;
        state_next  = proc ? state_calc : state_reg;
        in_vld_next = in_xfer ? 1'b1 : (proc ? 1'b0 : in_vld_reg);
    end

    u8u16_outq u_outq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .head  (head),
        .count (q_count)
    );

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            byte_reg <= in_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAPACITY_RESET;
            in_vld_reg   <= 1'b0;
            state_reg    <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                capacity_reg <= cfg_wr_data;
            end
            in_vld_reg <= in_vld_next;
            state_reg  <= state_next;
        end
    end

`ifndef ASSERT_OFF
    // dropped bytes never produce a result
    a_discard_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (proc && state_reg.discarding) |-> (step_calc.n_res == 2'd0))
        else $error("result produced while discarding");

    // no open sequence outside a multi-byte character
    a_seq_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.bytes_remaining == 2'd0) |->
            (state_reg.sequence_length == SEQ_NONE && state_reg.partial_point == '0))
        else $error("sequence state left over");

    // discarding only between sequences
    a_discard_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.discarding |-> (state_reg.bytes_remaining == 2'd0))
        else $error("discarding inside a sequence");

    // a decoded byte frees the input register unless a new one arrives
    a_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (proc && !in_xfer) |=> !in_vld_reg)
        else $error("input register not released");
`endif

endmodule

// ----- test/utf8_to_utf16_transcoder_core_tb.sv -----
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder_core_tb
// Self-checking bench for the UTF-8 to UTF-16 transcoder core.
// ----------------------------------------------------------------------------
// Streams zero-terminated UTF-8 strings into the core one byte per transfer
// and checks every code unit against a behavioral transcoder kept in the
// bench. A directed table covers the field extremes, the terminator, the
// surrogate pair and the error paths. Random strings follow: mostly valid
// text, mixed with overlong, surrogate, out-of-range, truncated and stray
// bytes, plus raw noise. The run goes through several capacity settings
// (zero and full scale among them) and several sender/receiver idle
// patterns, and holds the output off once to fill the core up.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import u8u16_pkg::*;

    localparam int RANDOM_BYTES      = 400;
    localparam int STRINGS_PER_PHASE = 5;
    localparam int HOLD_CYCLES       = 150;
    localparam int DRAIN_CYCLES      = 8;
    localparam int CYCLE_LIMIT       = 300000;

    localparam unit_res_t ERR_RES  = '{code_unit: 16'h0000, status: 1'b1, last: 1'b1};
    localparam unit_res_t TERM_RES = '{code_unit: 16'h0000, status: 1'b0, last: 1'b1};
    localparam unit_res_t NO_RES   = '0;

    typedef struct packed {
        logic [7:0] value;
        logic       typed;
        unit_res_t  want;
    } byte_row_t;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [15:0] cfg_wr_data = '0;
    logic        in_valid    = 1'b0;
    logic        in_stall;
    logic [7:0]  in_byte     = '0;
    logic        out_valid;
    logic        out_stall   = 1'b0;
    logic [15:0] code_unit;
    logic        status;
    logic        last;

    // transcoder state as the bench sees it
    logic [15:0] room_units = CAPACITY_RESET;
    logic [20:0] cp_accum   = '0;
    logic [1:0]  cont_left  = '0;
    logic [1:0]  seq_kind   = SEQ_NONE;
    logic [15:0] units_out  = '0;
    logic        skipping   = 1'b0;

    unit_res_t   pending_units[$];
    logic [7:0]  str_bytes[$];

    int          mismatch_count = 0;
    int          cycle_count    = 0;
    int          sent_bytes     = 0;
    int          send_idle_pct  = 0;
    int          stall_pct      = 0;
    int          hold_asks      = 0;
    int          hold_done      = 0;

    byte_row_t dir_rows [26] = '{
        '{8'h00, 1'b1, TERM_RES},
        '{8'h7F, 1'b1, '{16'h007F, 1'b0, 1'b0}},
        '{8'hC2, 1'b0, NO_RES},
        '{8'h80, 1'b0, NO_RES},
        '{8'hF4, 1'b0, NO_RES},
        '{8'h8F, 1'b0, NO_RES},
        '{8'hBF, 1'b0, NO_RES},
        '{8'hBF, 1'b0, NO_RES},
        '{8'h00, 1'b1, TERM_RES},
        // lead 0xF5 decodes past the top code point
        '{8'hF5, 1'b0, NO_RES},
        '{8'h80, 1'b0, NO_RES},
        '{8'h80, 1'b0, NO_RES},
        '{8'h80, 1'b1, ERR_RES},
        '{8'hFF, 1'b0, NO_RES},
        '{8'h00, 1'b0, NO_RES},
        // encoded surrogate
        '{8'hED, 1'b0, NO_RES},
        '{8'hA0, 1'b0, NO_RES},
        '{8'h80, 1'b1, ERR_RES},
        '{8'h00, 1'b0, NO_RES},
        // ascii where a continuation belongs
        '{8'hE1, 1'b0, NO_RES},
        '{8'h41, 1'b1, ERR_RES},
        '{8'h00, 1'b0, NO_RES},
        // string ends inside a sequence
        '{8'hE1, 1'b0, NO_RES},
        '{8'h00, 1'b1, ERR_RES},
        '{8'h80, 1'b1, ERR_RES},
        '{8'h00, 1'b0, NO_RES}
    };

    utf8_to_utf16_transcoder_core i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_byte     (in_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .code_unit   (code_unit),
        .status      (status),
        .last        (last)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic int abort_string(input logic keep_skipping, output unit_res_t u0);
        cp_accum  = '0;
        cont_left = '0;
        seq_kind  = SEQ_NONE;
        units_out = '0;
        skipping  = keep_skipping;
        u0 = ERR_RES;
        return 1;
    endfunction

    function automatic int emit_units(input logic [20:0] cp, output unit_res_t u0,
                                      output unit_res_t u1);
        logic [19:0] off;
        u0 = NO_RES;
        u1 = NO_RES;
        if (cp > 21'h00FFFF)
        begin
            if (int'(units_out) + 2 >= int'(room_units))
                return abort_string(1'b1, u0);
            off = 20'(cp - SUPP_OFFSET);
            u0 = '{HI_SURR_BASE + {6'b0, off[19:10]}, 1'b0, 1'b0};
            u1 = '{LO_SURR_BASE + {6'b0, off[9:0]}, 1'b0, 1'b0};
            units_out = units_out + 16'd2;
            return 2;
        end
        if (int'(units_out) + 1 >= int'(room_units))
            return abort_string(1'b1, u0);
        u0 = '{cp[15:0], 1'b0, 1'b0};
        units_out = units_out + 16'd1;
        return 1;
    endfunction

    // code units that one input byte causes, state updated in place
    function automatic int transcode_byte(input logic [7:0] c, output unit_res_t u0,
                                          output unit_res_t u1);
        logic [20:0] cp;
        logic        bad;
        u0 = NO_RES;
        u1 = NO_RES;
        if (skipping)
        begin
            if (c == 8'h00)
            begin
                skipping  = 1'b0;
                units_out = '0;
            end
            return 0;
        end
        if (cont_left != 2'd0)
        begin
            if (c[7:6] != 2'b10)
                return abort_string(c != 8'h00, u0);
            cp_accum  = {cp_accum[14:0], c[5:0]};
            cont_left = cont_left - 2'd1;
            if (cont_left != 2'd0)
                return 0;
            cp = cp_accum;
            case (seq_kind)
                SEQ_TWO:   bad = cp < MIN_TWO;
                SEQ_THREE: bad = cp < MIN_THREE || (cp >= SURR_FIRST && cp <= SURR_LAST);
                default:   bad = cp < MIN_FOUR || cp > MAX_POINT;
            endcase
            cp_accum = '0;
            seq_kind = SEQ_NONE;
            if (bad)
                return abort_string(1'b1, u0);
            return emit_units(cp, u0, u1);
        end
        if (c == 8'h00)
        begin
            if (units_out >= room_units)
                return abort_string(1'b0, u0);
            u0 = TERM_RES;
            units_out = '0;
            return 1;
        end
        if (c[7] == 1'b0)
            return emit_units({13'b0, c}, u0, u1);
        if (c[7:5] == 3'b110)
        begin
            cp_accum  = {16'b0, c[4:0]};
            cont_left = 2'd1;
            seq_kind  = SEQ_TWO;
            return 0;
        end
        if (c[7:4] == 4'b1110)
        begin
            cp_accum  = {17'b0, c[3:0]};
            cont_left = 2'd2;
            seq_kind  = SEQ_THREE;
            return 0;
        end
        if (c[7:3] == 5'b11110)
        begin
            cp_accum  = {18'b0, c[2:0]};
            cont_left = 2'd3;
            seq_kind  = SEQ_FOUR;
            return 0;
        end
        return abort_string(1'b1, u0);
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("ERROR %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin
        unit_res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_units.size() == 0)
                flag_mismatch($sformatf("unexpected code unit %h", code_unit));
            else
            begin
                want = pending_units.pop_front();
                if (code_unit !== want.code_unit)
                    flag_mismatch($sformatf("code_unit %h, wanted %h", code_unit,
                                            want.code_unit));
                if (status !== want.status)
                    flag_mismatch($sformatf("status %b, wanted %b", status, want.status));
                if (last !== want.last)
                    flag_mismatch($sformatf("last %b, wanted %b", last, want.last));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_done != hold_asks)
            begin
                hold_done = hold_asks;
                out_stall <= 1'b1;
                for (int k = 0; k < HOLD_CYCLES; k++)
                    @(posedge clk);
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic typed, input unit_res_t want);
        unit_res_t u0;
        unit_res_t u1;
        int        n;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        do
            @(posedge clk);
        while (in_stall);
        sent_bytes++;
        n = transcode_byte(b, u0, u1);
        if (typed)
            pending_units.push_back(want);
        else
        begin
            if (n > 0)
                pending_units.push_back(u0);
            if (n > 1)
                pending_units.push_back(u1);
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (pending_units.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_room(input logic [15:0] v);
        cfg_wr_data <= v;
        cfg_wr_en   <= 1'b1;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        room_units = v;
    endtask

    function automatic void encode_point(input logic [20:0] cp, input int nbytes);
        case (nbytes)
            1: str_bytes.push_back(cp[7:0]);
            2:
            begin
                str_bytes.push_back({3'b110, cp[10:6]});
                str_bytes.push_back({2'b10, cp[5:0]});
            end
            3:
            begin
                str_bytes.push_back({4'b1110, cp[15:12]});
                str_bytes.push_back({2'b10, cp[11:6]});
                str_bytes.push_back({2'b10, cp[5:0]});
            end
            default:
            begin
                str_bytes.push_back({5'b11110, cp[20:18]});
                str_bytes.push_back({2'b10, cp[17:12]});
                str_bytes.push_back({2'b10, cp[11:6]});
                str_bytes.push_back({2'b10, cp[5:0]});
            end
        endcase
    endfunction

    // one character, well formed most of the time
    function automatic void add_char();
        logic [20:0] cp;
        int          pick;
        int          n;
        pick = $urandom_range(99);
        if (pick < 40)
            encode_point(21'($urandom_range(127, 1)), 1);
        else if (pick < 52)
            encode_point(21'($urandom_range(21'h0007FF, 21'h000080)), 2);
        else if (pick < 64)
        begin
            cp = 21'($urandom_range(21'h00FFFF, 21'h000800));
            if (cp >= SURR_FIRST && cp <= SURR_LAST)
                cp = cp ^ 21'h002000;
            encode_point(cp, 3);
        end
        else if (pick < 76)
            encode_point(21'($urandom_range(MAX_POINT, MIN_FOUR)), 4);
        else
        begin
            case ($urandom_range(5))
                0:
                begin
                    // overlong form
                    n = $urandom_range(4, 2);
                    cp = (n == 2) ? 21'($urandom_range(21'h00007F, 0)) :
                         (n == 3) ? 21'($urandom_range(21'h0007FF, 0)) :
                                    21'($urandom_range(21'h00FFFF, 0));
                    encode_point(cp, n);
                end
                1: encode_point(21'($urandom_range(SURR_LAST, SURR_FIRST)), 3);
                2: encode_point(21'($urandom_range(21'h1FFFFF, 21'h110000)), 4);
                3: str_bytes.push_back($urandom_range(1) ? 8'($urandom_range(8'hBF, 8'h80))
                                                         : 8'($urandom_range(8'hFF, 8'hF8)));
                4:
                begin
                    // sequence cut short
                    encode_point(21'($urandom_range(MAX_POINT, 21'h000080)),
                                 $urandom_range(4, 2));
                    void'(str_bytes.pop_back());
                end
                default: str_bytes.push_back(8'($urandom_range(8'hFF, 8'h01)));
            endcase
        end
    endfunction

    task automatic send_string(input logic noise);
        str_bytes.delete();
        if (noise)
            repeat ($urandom_range(10, 1))
                str_bytes.push_back(8'($urandom_range(8'hFF, 8'h00)));
        else
            repeat ($urandom_range(8)) add_char();
        str_bytes.push_back(8'h00);
        foreach (str_bytes[i])
            send_byte(str_bytes[i], 1'b0, NO_RES);
    endtask

    initial
    begin
        int ph;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_byte(dir_rows[i].value, dir_rows[i].typed, dir_rows[i].want);

        // hold the output off while a long string keeps coming
        settle();
        hold_asks++;
        str_bytes.delete();
        repeat (30) add_char();
        str_bytes.push_back(8'h00);
        foreach (str_bytes[i])
            send_byte(str_bytes[i], 1'b0, NO_RES);

        sent_bytes = 0;
        ph = 0;
        while (sent_bytes < RANDOM_BYTES || ph < 8)
        begin
            settle();
            case (ph % 7)
                0: set_room(16'hFFFF);
                1: set_room(16'd0);
                2: set_room(16'd1);
                3: set_room(16'd2);
                4: set_room(16'd3);
                5: set_room(16'($urandom_range(40, 4)));
                default: set_room(16'($urandom_range(16'hFFFF, 0)));
            endcase
            case (ph % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    send_idle_pct = 53;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 53;
                end
                default:
                begin
                    send_idle_pct = 22;
                    stall_pct     = 22;
                end
            endcase
            repeat (STRINGS_PER_PHASE) send_string($urandom_range(5) == 0);
            ph++;
        end

        settle();
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
